### src/llh_pkg.sv
// shared types and constants for the latency log histogram
package llh_pkg;

  localparam int unsigned LATENCY_W       = 32;
  localparam int unsigned BIN_INDEX_W     = 9;
  localparam int unsigned COUNT_W         = 32;
  localparam int unsigned TOTAL_W         = 64;
  localparam int unsigned BINS_PER_DECADE = 100;
  localparam int unsigned QUOT_W          = 7;
  localparam int unsigned MAX_DECADES     = 6;
  localparam int unsigned S_TDATA_W       = 48;
  localparam int unsigned M_TDATA_W       = 192;

  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int unsigned DIV10_SHIFT = 35;

  typedef enum logic [0:0] {
    CMD_RECORD = 1'b0,
    CMD_READ   = 1'b1
  } llh_cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOCATE,
    ST_DIVIDE,
    ST_READ,
    ST_UPDATE,
    ST_FINISH
  } llh_state_e;

  // upper bound of decade d: 100 * 10^d
  function automatic logic [31:0] decade_limit(int unsigned d);
    logic [31:0] v;
    v = 32'd100;
    for (int unsigned k = 0; k < MAX_DECADES; k++) begin
      if (k < d) begin
        v = v * 32'd10;
      end
    end
    return v;
  endfunction

endpackage

### src/latency_log_histogram.sv
// latency statistics block with a memory-backed decade histogram
//
//  channel  dir  tdata (low bit up)                                      tuser
//  s_axis   in   latency_ms[31:0], bin_index[40:32], zero pad [47:41]      command
//  m_axis   out  bin_count, lat_min, lat_max, lat_sum,                     -
//                overflow_count
//
// a record in decade d makes d divide-by-ten steps, then a read, modify and write of the
// bin memory
// valid bin reads pass read and update; overflow samples and out-of-range reads skip both
// after reset a clearing pass zeroes all DECADES*100 bins, s_axis_tready low
// a finished result waits in the output register while the next transaction is taken
module latency_log_histogram #(
  parameter int unsigned DECADES = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // latency_ms, bin_index
  input  logic [llh_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // command
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // bin_count, lat_min, lat_max, lat_sum, overflow_count
  output logic [llh_pkg::M_TDATA_W-1:0]    m_axis_tdata
);
  import llh_pkg::*;

  localparam int unsigned BINS   = DECADES * BINS_PER_DECADE;
  localparam int unsigned ADDR_W = $clog2(BINS);
  localparam int unsigned DEC_W  = (DECADES > 1) ? $clog2(DECADES) : 1;
  localparam int unsigned IDX_W  = (BIN_INDEX_W > ADDR_W) ? BIN_INDEX_W : ADDR_W;

  llh_state_e state_q, state_d;

  logic [ADDR_W-1:0]      clr_cnt_q;
  llh_cmd_e               cmd_q;
  logic [LATENCY_W-1:0]   x_q, x_d;
  logic [BIN_INDEX_W-1:0] idx_q;
  logic [DEC_W-1:0]       dec_q, dec_d;
  logic [DEC_W-1:0]       div_cnt_q, div_cnt_d;
  logic [ADDR_W-1:0]      addr_q;
  logic [COUNT_W-1:0]     rd_data_q;
  logic [COUNT_W-1:0]     count_q, count_d;

  logic [LATENCY_W-1:0]   min_q, min_d;
  logic [LATENCY_W-1:0]   max_q, max_d;
  logic [TOTAL_W-1:0]     sum_q, sum_d;
  logic [COUNT_W-1:0]     ovf_q, ovf_d;

  logic                   out_valid_q;
  logic [M_TDATA_W-1:0]   out_data_q;

  logic [COUNT_W-1:0]     bins_mem [BINS];

  logic                   in_fire;
  logic                   out_load;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_waddr;
  logic [COUNT_W-1:0]     mem_wdata;
  logic                   mem_re;
  logic [ADDR_W-1:0]      bin_pos;
  logic [COUNT_W-1:0]     bin_inc;

  logic                   loc_ovf;
  logic [DEC_W-1:0]       loc_dec;
  logic [IDX_W-1:0]       idx_wide;
  logic                   idx_ok;
  logic [TOTAL_W:0]       sum_ext;
  logic [63:0]            div_prod;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign idx_wide = IDX_W'(idx_q);
  assign idx_ok   = idx_wide < IDX_W'(BINS);
  assign sum_ext  = {1'b0, sum_q} + (TOTAL_W + 1)'(x_q);
  assign div_prod = 64'(x_q) * 64'(DIV10_MAGIC);
  assign bin_inc  = (rd_data_q == '1) ? rd_data_q : rd_data_q + COUNT_W'(1);

  // decade search over constant limits
  always_comb begin
    loc_ovf = 1'b1;
    loc_dec = '0;
    for (int d = DECADES - 1; d >= 0; d--) begin
      if (x_q < decade_limit(d)) begin
        loc_ovf = 1'b0;
        loc_dec = DEC_W'(d);
      end
    end
  end

  always_comb begin
    if (cmd_q == CMD_READ) begin
      bin_pos = idx_wide[ADDR_W-1:0];
    end else begin
      bin_pos = ADDR_W'(32'(dec_q) * 32'(BINS_PER_DECADE) + 32'(x_q[QUOT_W-1:0]));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == ADDR_W'(BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOCATE;
        end
      end
      ST_LOCATE: begin
        priority if (cmd_q == CMD_READ) begin
          state_d = idx_ok ? ST_READ : ST_FINISH;
        end else if (loc_ovf) begin
          state_d = ST_FINISH;
        end else if (loc_dec == '0) begin
          state_d = ST_READ;
        end else begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_cnt_q == DEC_W'(1)) begin
          state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_FINISH;
      ST_FINISH: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_CLEAR;
    endcase
  end

  // outputs and datapath
  always_comb begin
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_q;
    mem_wdata     = bin_inc;
    mem_re        = 1'b0;
    x_d           = x_q;
    dec_d         = dec_q;
    div_cnt_d     = div_cnt_q;
    count_d       = count_q;
    min_d         = min_q;
    max_d         = max_q;
    sum_d         = sum_q;
    ovf_d         = ovf_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        x_d           = s_axis_tdata[LATENCY_W-1:0];
      end
      ST_LOCATE: begin
        count_d   = '0;
        dec_d     = loc_dec;
        div_cnt_d = loc_dec;
        if (cmd_q == CMD_RECORD) begin
          if (x_q > max_q) begin
            max_d = x_q;
          end
          if (min_q == '0 || x_q < min_q) begin
            min_d = x_q;
          end
          sum_d = sum_ext[TOTAL_W] ? '1 : sum_ext[TOTAL_W-1:0];
          if (loc_ovf && ovf_q != '1) begin
            ovf_d = ovf_q + COUNT_W'(1);
          end
        end
      end
      ST_DIVIDE: begin
        x_d       = LATENCY_W'(div_prod >> DIV10_SHIFT);
        div_cnt_d = div_cnt_q - DEC_W'(1);
      end
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_UPDATE: begin
        if (cmd_q == CMD_RECORD) begin
          mem_we  = 1'b1;
          count_d = bin_inc;
        end else begin
          count_d = rd_data_q;
        end
      end
      ST_FINISH: begin
        out_load = !out_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bins_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= bins_mem[bin_pos];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      min_q       <= '0;
      max_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q   <= state_d;
      min_q     <= min_d;
      max_q     <= max_d;
      sum_q     <= sum_d;
      ovf_q     <= ovf_d;
      div_cnt_q <= div_cnt_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    dec_q   <= dec_d;
    count_q <= count_d;
    if (in_fire) begin
      cmd_q <= llh_cmd_e'(s_axis_tuser[0]);
      idx_q <= s_axis_tdata[LATENCY_W +: BIN_INDEX_W];
    end
    if (mem_re) begin
      addr_q <= bin_pos;
    end
    if (out_load) begin
      out_data_q <= {ovf_q, sum_q, max_q, min_q, count_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_accept_locates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q == ST_LOCATE)
    else $error("accepted transaction did not start bin location");

  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR) || (state_q == ST_UPDATE && cmd_q == CMD_RECORD))
    else $error("bin memory written outside clear or record update");

  a_sum_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> sum_q >= $past(sum_q))
    else $error("total latency decreased");

  a_ovf_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ovf_q >= $past(ovf_q))
    else $error("overflow count decreased");

endmodule
